FILE: rtl/phr_pkg.sv
// Shared types, constants and helpers for the pose history rate estimator.
// Depends on nothing; every other file in rtl uses it by scoped names.
package phr_pkg;

    localparam int HIST_DEPTH = 8;
    localparam int IDX_W      = $clog2(HIST_DEPTH);
    localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

    localparam int MAG_W      = 33;
    localparam int DIFF_W     = 34;
    localparam int RATE_K     = (HIST_DEPTH - 1) * 1000000;
    localparam int RATE_W     = $clog2(RATE_K + 1);
    localparam int NUM_W      = MAG_W + RATE_W;
    localparam int QCNT_W     = $clog2(NUM_W + 1);

    localparam int NUM_OPS    = 9;
    localparam int OP_W       = $clog2(NUM_OPS + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_MERGE_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_OFFSET = 2'd1;

    localparam logic [19:0] MERGE_WINDOW_RST = 20'd10000;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [15:0] y;
        logic signed [15:0] x;
        logic        [31:0] t;
    } sample_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [MAG_W-1:0] den;
        logic             neg;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [31:0] quot;
    } div_rsp_t;

    // history index taken modulo the depth
    function automatic logic [IDX_W-1:0] mod_depth(input logic [2:0] v);
        int tmp;
        tmp = int'(v);
        for (int i = 0; i < 3; i++) begin
            if (tmp >= HIST_DEPTH) begin
                tmp = tmp - HIST_DEPTH;
            end
        end
        return IDX_W'(tmp);
    endfunction

    function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] v);
        logic [IDX_W:0] s;
        s = {1'b0, v} + 1'b1;
        if (s >= (IDX_W+1)'(HIST_DEPTH)) begin
            s = '0;
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

FILE: rtl/phr_hist_mem.sv
// Sample history memory: one write and one registered read port.
// Entries never written read as zero through per-entry valid bits. Uses phr_pkg.
module phr_hist_mem (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      wr_en,
    input  logic [phr_pkg::IDX_W-1:0] wr_addr,
    input  phr_pkg::sample_t          wr_data,
    input  logic                      rd_en,
    input  logic [phr_pkg::IDX_W-1:0] rd_addr,
    output phr_pkg::sample_t          rd_data
);

    phr_pkg::sample_t                 mem [phr_pkg::HIST_DEPTH];
    logic [phr_pkg::HIST_DEPTH-1:0]   valid_reg;
    phr_pkg::sample_t                 rd_data_reg;
    logic                             rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

FILE: rtl/phr_div.sv
// Restoring divider, one quotient bit a cycle, with signed saturation to 32 bits.
// Uses phr_pkg for widths and the request and response structs.
module phr_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  phr_pkg::div_req_t req,
    output phr_pkg::div_rsp_t rsp
);

    localparam logic [phr_pkg::NUM_W-1:0] MIN_MAG = phr_pkg::NUM_W'(64'h8000_0000);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [phr_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;
    logic [phr_pkg::NUM_W-1:0]    num_reg, num_next;
    logic [phr_pkg::NUM_W-1:0]    quo_reg, quo_next;
    logic [phr_pkg::MAG_W:0]      rem_reg, rem_next;
    logic [phr_pkg::MAG_W-1:0]    den_reg, den_next;
    logic                         neg_reg, neg_next;
    logic [phr_pkg::MAG_W:0]      shifted;
    logic                         qbit;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        shifted   = {rem_reg[phr_pkg::MAG_W-1:0], num_reg[phr_pkg::NUM_W-1]};
        qbit      = shifted >= {1'b0, den_reg};
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = phr_pkg::QCNT_W'(phr_pkg::NUM_W);
            num_next  = req.num;
            den_next  = req.den;
            neg_next  = req.neg;
            rem_next  = '0;
            quo_next  = '0;
        end else if (busy_reg) begin
            rem_next = qbit ? shifted - {1'b0, den_reg} : shifted;
            quo_next = {quo_reg[phr_pkg::NUM_W-2:0], qbit};
            num_next = {num_reg[phr_pkg::NUM_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == phr_pkg::QCNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    always_comb begin
        rsp.busy = busy_reg;
        rsp.done = done_reg;
        if (neg_reg) begin
            rsp.quot = (quo_reg >= MIN_MAG) ? 32'sh8000_0000 : -$signed(quo_reg[31:0]);
        end else begin
            rsp.quot = (quo_reg > MIN_MAG - 1'b1) ? 32'sh7fff_ffff : $signed(quo_reg[31:0]);
        end
    end

endmodule

FILE: rtl/pose_history_rate_estimator.sv
// Top level of the pose history rate estimator: sequencer, arithmetic and ports.
// Depends on phr_pkg, phr_hist_mem and phr_div.
//
// Takes timestamped pose samples (time in us, x/y in mm, unwrapped heading in urad)
// and keeps the last HIST_DEPTH of them in a small synchronous memory, newest first.
// A sample closer in time than merge_window to the newest one overwrites it; any
// other sample is pushed and the oldest drops out. For every sample one result
// transaction follows with finite-difference velocity and acceleration at history
// index query_offset, scaled by the mean step over the whole history, saturated to
// 32 bits, plus flags for nonzero span, strict time ordering and merge. The memory
// sweep reads one entry a cycle and the nine quotients share one restoring divider
// that retires one bit a cycle. The output register lets a result wait for m_tready
// while the next sample is taken; no clearing pass follows reset.
module pose_history_rate_estimator (
    input  logic                            aclk,
    input  logic                            aresetn,
    // t[31:0] sample_time, [47:32] pos_x, [63:48] pos_y, [95:64] heading
    input  logic [95:0]                     s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] vel_x, vel_y, turn_rate, acc_x, acc_y, [191:160] turn_accel
    output logic [191:0]                    m_tdata,
    // [0] rates_valid, [1] history_ordered, [2] merged
    output logic [2:0]                      m_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_we,
    input  logic [phr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [phr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_LOOK  = 8'b0000_0010,
        ST_SWEEP = 8'b0000_0100,
        ST_SPAN  = 8'b0000_1000,
        ST_MUL   = 8'b0001_0000,
        ST_START = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    localparam int D = phr_pkg::HIST_DEPTH;
    localparam int IW = phr_pkg::IDX_W;

    state_t                          state_reg, state_next;
    logic [19:0]                     merge_window_reg;
    logic [2:0]                      query_offset_reg;
    logic [IW-1:0]                   newest_reg, newest_next;
    phr_pkg::sample_t                in_reg;
    logic                            merged_reg, merged_next;
    logic                            ordered_reg, ordered_next;
    logic [phr_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                            pend_reg, pend_next;
    logic [IW-1:0]                   pend_j_reg, pend_j_next;
    logic [31:0]                     prev_t_reg, prev_t_next;
    logic [31:0]                     t0_reg, t0_next;
    logic [31:0]                     tl_reg, tl_next;
    phr_pkg::sample_t                p0_reg, p0_next, p1_reg, p1_next, p2_reg, p2_next;
    logic [phr_pkg::MAG_W-1:0]       span_mag_reg, span_mag_next;
    logic                            span_neg_reg, span_neg_next;
    logic                            valid_reg, valid_next;
    logic [phr_pkg::OP_W-1:0]        op_reg, op_next;
    logic [phr_pkg::NUM_W-1:0]       prod_reg, prod_next;
    logic                            qneg_reg, qneg_next;
    logic signed [31:0]              res_reg [phr_pkg::NUM_OPS];
    logic signed [31:0]              res_next [phr_pkg::NUM_OPS];
    logic [191:0]                    m_tdata_reg, m_tdata_next;
    logic [2:0]                      m_tuser_reg, m_tuser_next;
    logic                            m_tvalid_reg, m_tvalid_next;

    logic                            mem_we, mem_re;
    logic [IW-1:0]                   mem_waddr, mem_raddr;
    phr_pkg::sample_t                mem_wdata, mem_rdata;
    phr_pkg::div_req_t               div_req;
    phr_pkg::div_rsp_t               div_rsp;

    logic [IW-1:0]                   k_idx, k1_idx, k2_idx;
    logic signed [32:0]              gap;
    logic [32:0]                     gap_mag;
    logic signed [32:0]              span;
    logic signed [phr_pkg::DIFF_W-1:0] opa, opb, diff;
    logic [phr_pkg::MAG_W-1:0]       diff_mag;
    logic [IW:0]                     slot_sum;

    phr_hist_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    phr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign k_idx  = phr_pkg::mod_depth(query_offset_reg);
    assign k1_idx = phr_pkg::inc_idx(k_idx);
    assign k2_idx = phr_pkg::inc_idx(k1_idx);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tvalid = m_tvalid_reg;

    // configuration writes: indices beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            merge_window_reg <= phr_pkg::MERGE_WINDOW_RST;
            query_offset_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                phr_pkg::CFG_MERGE_WINDOW: merge_window_reg <= cfg_wdata;
                phr_pkg::CFG_QUERY_OFFSET: query_offset_reg <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // operand selection for the current quotient: six velocities, then three accelerations
    always_comb begin
        case (op_reg)
            4'd0: begin opa = phr_pkg::DIFF_W'(p0_reg.x); opb = phr_pkg::DIFF_W'(p1_reg.x); end
            4'd1: begin opa = phr_pkg::DIFF_W'(p1_reg.x); opb = phr_pkg::DIFF_W'(p2_reg.x); end
            4'd2: begin opa = phr_pkg::DIFF_W'(p0_reg.y); opb = phr_pkg::DIFF_W'(p1_reg.y); end
            4'd3: begin opa = phr_pkg::DIFF_W'(p1_reg.y); opb = phr_pkg::DIFF_W'(p2_reg.y); end
            4'd4: begin opa = phr_pkg::DIFF_W'(p0_reg.a); opb = phr_pkg::DIFF_W'(p1_reg.a); end
            4'd5: begin opa = phr_pkg::DIFF_W'(p1_reg.a); opb = phr_pkg::DIFF_W'(p2_reg.a); end
            4'd6: begin opa = phr_pkg::DIFF_W'(res_reg[0]); opb = phr_pkg::DIFF_W'(res_reg[1]); end
            4'd7: begin opa = phr_pkg::DIFF_W'(res_reg[2]); opb = phr_pkg::DIFF_W'(res_reg[3]); end
            4'd8: begin opa = phr_pkg::DIFF_W'(res_reg[4]); opb = phr_pkg::DIFF_W'(res_reg[5]); end
            default: begin opa = '0; opb = '0; end
        endcase
    end

    assign diff     = opa - opb;
    assign diff_mag = diff[phr_pkg::DIFF_W-1] ? phr_pkg::MAG_W'(-diff)
                                               : phr_pkg::MAG_W'(diff);
    assign gap      = $signed({1'b0, in_reg.t}) - $signed({1'b0, mem_rdata.t});
    assign gap_mag  = gap[32] ? 33'(-gap) : 33'(gap);
    assign span     = $signed({1'b0, t0_reg}) - $signed({1'b0, tl_reg});

    always_comb begin
        state_next    = state_reg;
        newest_next   = newest_reg;
        merged_next   = merged_reg;
        ordered_next  = ordered_reg;
        cnt_next      = cnt_reg;
        pend_next     = 1'b0;
        pend_j_next   = pend_j_reg;
        prev_t_next   = prev_t_reg;
        t0_next       = t0_reg;
        tl_next       = tl_reg;
        p0_next       = p0_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        span_mag_next = span_mag_reg;
        span_neg_next = span_neg_reg;
        valid_next    = valid_reg;
        op_next       = op_reg;
        prod_next     = prod_reg;
        qneg_next     = qneg_reg;
        res_next      = res_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        mem_we        = 1'b0;
        mem_waddr     = newest_reg;
        mem_wdata     = in_reg;
        mem_re        = 1'b0;
        mem_raddr     = newest_reg;
        slot_sum      = {1'b0, newest_reg} + (IW+1)'(cnt_reg);
        div_req.start = 1'b0;
        div_req.num   = prod_reg;
        div_req.den   = span_mag_reg;
        div_req.neg   = qneg_reg;

        case (state_reg)
            ST_IDLE: begin
                // fetch the newest entry to decide merge or push
                if (s_tvalid) begin
                    mem_re     = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                merged_next = gap_mag < {13'd0, merge_window_reg};
                if (!merged_next) begin
                    newest_next = (newest_reg == '0) ? IW'(D - 1) : newest_reg - 1'b1;
                end
                mem_we       = 1'b1;
                mem_waddr    = newest_next;
                cnt_next     = '0;
                ordered_next = 1'b1;
                state_next   = ST_SWEEP;
            end
            ST_SWEEP: begin
                // issue one read a cycle, newest first; consume the previous one
                if (cnt_reg < phr_pkg::CNT_W'(D)) begin
                    mem_re      = 1'b1;
                    mem_raddr   = (slot_sum >= (IW+1)'(D)) ? IW'(slot_sum - (IW+1)'(D))
                                                           : slot_sum[IW-1:0];
                    cnt_next    = cnt_reg + 1'b1;
                    pend_next   = 1'b1;
                    pend_j_next = cnt_reg[IW-1:0];
                end
                if (pend_reg) begin
                    prev_t_next = mem_rdata.t;
                    if (pend_j_reg == '0) begin
                        t0_next = mem_rdata.t;
                    end else if (prev_t_reg <= mem_rdata.t) begin
                        ordered_next = 1'b0;
                    end
                    if (pend_j_reg == k_idx) p0_next = mem_rdata;
                    if (pend_j_reg == k1_idx) p1_next = mem_rdata;
                    if (pend_j_reg == k2_idx) p2_next = mem_rdata;
                    if (pend_j_reg == IW'(D - 1)) begin
                        tl_next    = mem_rdata.t;
                        state_next = ST_SPAN;
                    end
                end
            end
            ST_SPAN: begin
                span_neg_next = span[32];
                span_mag_next = span[32] ? phr_pkg::MAG_W'(-span) : phr_pkg::MAG_W'(span);
                valid_next    = span != '0;
                for (int i = 0; i < phr_pkg::NUM_OPS; i++) begin
                    res_next[i] = '0;
                end
                op_next    = '0;
                state_next = (span != '0) ? ST_MUL : ST_OUT;
            end
            ST_MUL: begin
                prod_next  = phr_pkg::NUM_W'(diff_mag) * phr_pkg::NUM_W'(phr_pkg::RATE_K);
                qneg_next  = diff[phr_pkg::DIFF_W-1] ^ span_neg_reg;
                state_next = ST_START;
            end
            ST_START: begin
                div_req.start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    res_next[op_reg[phr_pkg::OP_W-1:0]] = div_rsp.quot;
                    op_next    = op_reg + 1'b1;
                    state_next = (op_reg == phr_pkg::OP_W'(phr_pkg::NUM_OPS - 1)) ? ST_OUT
                                                                                    : ST_MUL;
                end
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {res_reg[8], res_reg[7], res_reg[6],
                                     res_reg[4], res_reg[2], res_reg[0]};
                    m_tuser_next  = {merged_reg, ordered_reg, valid_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            newest_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            pend_reg     <= 1'b0;
            cnt_reg      <= '0;
            op_reg       <= '0;
        end else begin
            state_reg    <= state_next;
            newest_reg   <= newest_next;
            m_tvalid_reg <= m_tvalid_next;
            pend_reg     <= pend_next;
            cnt_reg      <= cnt_next;
            op_reg       <= op_next;
        end
        if (s_tvalid && s_tready) begin
            in_reg <= phr_pkg::sample_t'(s_tdata);
        end
        merged_reg   <= merged_next;
        ordered_reg  <= ordered_next;
        pend_j_reg   <= pend_j_next;
        prev_t_reg   <= prev_t_next;
        t0_reg       <= t0_next;
        tl_reg       <= tl_next;
        p0_reg       <= p0_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        span_mag_reg <= span_mag_next;
        span_neg_reg <= span_neg_next;
        valid_reg    <= valid_next;
        prod_reg     <= prod_next;
        qneg_reg     <= qneg_next;
        res_reg      <= res_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    // zero span must leave every rate at zero
    a_zero_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("rates nonzero with zero span");

    // the divider only runs while the sequencer waits on it
    a_div_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.busy |-> (state_reg == ST_DIV))
        else $error("divider busy outside its state");

    // the newest slot moves exactly when a sample is pushed
    a_push_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOK) |=> ((newest_reg == $past(newest_reg)) == merged_reg))
        else $error("newest slot inconsistent with merge decision");

    // a new result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && state_reg == ST_OUT) |=> (state_reg == ST_OUT))
        else $error("result overwritten before transfer");

endmodule
